/* hw/rtl/mcpwc_pkg.sv */
// Shared types and constants for the multi-channel pulse width capture block.
package mcpwc_pkg;

    localparam int PIN_W           = 8;
    localparam int COUNT_W         = 16;
    localparam int WIDTH_W         = 22;
    localparam int CHAN_FIELD_W    = 3;
    localparam int TDATA_OUT_W     = 32;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam int DEF_CHANNELS      = 8;
    localparam int DEF_MAX_OVERFLOWS = 63;

    localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'hFFFF;
    localparam logic [WIDTH_W-1:0] THRESH_RESET = 22'd2500;

    typedef enum logic [0:0] {
        REG_PERIOD = 1'b0,
        REG_THRESH = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                    res;
        logic                    item_end;
        logic [CHAN_FIELD_W-1:0] chan;
        logic [WIDTH_W-1:0]      width;
    } cap_res_t;

endpackage

/* hw/rtl/mcpwc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mcpwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mcpwc_proc.sv */
// Channel sequencer and read-modify-write stage over the per-channel state RAM.
module mcpwc_proc
    import mcpwc_pkg::*;
#(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int MAX_OVERFLOWS = DEF_MAX_OVERFLOWS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIN_W-1:0]   pin_levels,
    input  logic [COUNT_W-1:0] period,
    input  logic [WIDTH_W-1:0] threshold,
    input  logic               stall,
    output logic               cap_valid,
    output cap_res_t           cap
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OW = $clog2(MAX_OVERFLOWS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(CHANNELS - 1);
    localparam logic [OW-1:0] MAX_OVF  = OW'(MAX_OVERFLOWS);

    typedef struct packed {
        logic [WIDTH_W-1:0] lastw;
        logic               act;
        logic [OW-1:0]      ovf;
        logic [COUNT_W-1:0] cnt;
    } entry_t;

    localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'({MAX_OVF, {COUNT_W{1'b1}}});

    logic                busy_reg;
    logic [CW-1:0]       idx_reg;
    logic [CHANNELS-1:0] lv_reg;
    logic [CHANNELS-1:0] pv_reg;
    logic [CHANNELS-1:0] lv_in;
    logic [CHANNELS-1:0] vld_reg;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_ch_reg;
    logic          s1_cur_reg;
    logic          s1_prev_reg;
    logic          s1_last_reg;
    logic          fwd_valid_reg;
    entry_t        fwd_data_reg;
    logic          rd_vld_reg;

    logic   s1_adv;
    logic   issue;
    logic   last_idx;
    logic   accept;
    entry_t ram_q;
    entry_t ent;
    entry_t ent_next;
    logic   done;
    logic   pass;
    logic [WIDTH_W-1:0] w;
    logic [WIDTH_W-1:0] up;
    logic [WIDTH_W-1:0] down;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lv
        if (i < PIN_W) begin : g_pin
            assign lv_in[i] = pin_levels[i];
        end else begin : g_zero
            assign lv_in[i] = 1'b0;
        end
    end

    assign s1_adv   = s1_valid_reg && !stall;
    assign issue    = busy_reg && (!s1_valid_reg || s1_adv);
    assign last_idx = (idx_reg == LAST_IDX);
    assign s_tready = !busy_reg || (issue && last_idx);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            lv_reg   <= '0;
            pv_reg   <= '0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            lv_reg   <= lv_in;
            pv_reg   <= lv_reg;
        end else if (issue && last_idx) begin
            busy_reg <= 1'b0;
        end else if (issue) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (issue) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (s1_adv) begin
            vld_reg[s1_ch_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (issue) begin
            fwd_valid_reg <= s1_adv && (s1_ch_reg == idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_ch_reg    <= idx_reg;
            s1_cur_reg   <= lv_reg[idx_reg];
            s1_prev_reg  <= pv_reg[idx_reg];
            s1_last_reg  <= last_idx;
            fwd_data_reg <= ent_next;
            rd_vld_reg   <= vld_reg[idx_reg];
        end
    end

    mcpwc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_ch_reg),
        .wr_data (ent_next),
        .rd_en   (issue),
        .rd_addr (idx_reg),
        .rd_data (ram_q)
    );

    always_comb begin
        if (fwd_valid_reg) begin
            ent = fwd_data_reg;
        end else if (rd_vld_reg) begin
            ent = ram_q;
        end else begin
            ent = '0;
        end
    end

    always_comb begin
        ent_next = ent;
        done     = 1'b0;
        w        = '0;
        if (s1_cur_reg && !s1_prev_reg) begin
            ent_next.cnt = '0;
            ent_next.ovf = '0;
            ent_next.act = 1'b1;
        end else if (ent.act) begin
            if (!s1_cur_reg) begin
                w            = WIDTH_W'({ent.ovf, ent.cnt});
                ent_next.act = 1'b0;
                done         = 1'b1;
            end else if (ent.cnt >= period) begin
                ent_next.cnt = '0;
                if (ent.ovf >= MAX_OVF) begin
                    w            = MAX_WIDTH;
                    ent_next.act = 1'b0;
                    done         = 1'b1;
                end else begin
                    ent_next.ovf = ent.ovf + 1'b1;
                end
            end else begin
                ent_next.cnt = ent.cnt + 1'b1;
            end
        end
        up   = w - ent.lastw;
        down = ent.lastw - w;
        pass = done && ((up < threshold) || (down > threshold));
        if (pass) begin
            ent_next.lastw = w;
        end
    end

    assign cap_valid    = s1_valid_reg;
    assign cap.res      = pass;
    assign cap.item_end = s1_last_reg;
    assign cap.chan     = CHAN_FIELD_W'(s1_ch_reg);
    assign cap.width    = w;

endmodule

/* hw/rtl/mcpwc_out.sv */
// Pending result holder and output register; marks the final result of each item.
module mcpwc_out
    import mcpwc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cap_valid,
    input  cap_res_t               cap,
    output logic                   stall,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic                    pend_valid_reg;
    logic                    pend_final_reg;
    logic [CHAN_FIELD_W-1:0] pend_chan_reg;
    logic [WIDTH_W-1:0]      pend_width_reg;
    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic [CHAN_FIELD_W-1:0] m_chan_reg;
    logic [WIDTH_W-1:0]      m_width_reg;

    logic out_free;
    logic has_res;
    logic adv;
    logic push;

    assign out_free = !m_valid_reg || m_tready;
    assign has_res  = cap_valid && cap.res;
    assign stall    = has_res && pend_valid_reg && !out_free;
    assign adv      = cap_valid && !stall;
    assign push     = out_free && pend_valid_reg && (pend_final_reg || has_res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_last_reg  <= pend_final_reg;
            m_chan_reg  <= pend_chan_reg;
            m_width_reg <= pend_width_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
        end else if (adv && has_res) begin
            pend_valid_reg <= 1'b1;
            pend_final_reg <= cap.item_end;
        end else if (push) begin
            pend_valid_reg <= 1'b0;
        end else if (adv && cap.item_end) begin
            pend_final_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && has_res) begin
            pend_chan_reg  <= cap.chan;
            pend_width_reg <= cap.width;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = TDATA_OUT_W'({m_width_reg, m_chan_reg});

endmodule

/* hw/rtl/multi_channel_pulse_width_capture_top.sv */
// Top level: configuration registers, channel processor and result output.
// Items: each channel of a tick item takes one slot on the state RAM read port, and the
//   next item is taken as the last channel is read; an output stall holds the sequence.
// Results: results reach m_tdata through a pending holder and the output register;
//   the final result of an item waits until every channel of that item is done.
// Reset: synchronous, active low; clears control, entry valid bits, previous levels and
//   the registers (period 65535, threshold 2500). RAM contents read as zero until written.
module multi_channel_pulse_width_capture_top
    import mcpwc_pkg::*;
#(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int MAX_OVERFLOWS = DEF_MAX_OVERFLOWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIN_W-1:0]       s_tdata,    // [7:0] pin_levels
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // [2:0] channel, [24:3] width, rest zero
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [COUNT_W-1:0] period_reg;
    logic [WIDTH_W-1:0] thresh_reg;
    reg_idx_t           reg_sel;
    logic               stall;
    logic               cap_valid;
    cap_res_t           cap;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_PERIOD: period_reg <= pwdata[COUNT_W-1:0];
                REG_THRESH: thresh_reg <= pwdata[WIDTH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_PERIOD: prdata = APB_DATA_W'(period_reg);
            REG_THRESH: prdata = APB_DATA_W'(thresh_reg);
            default:    prdata = '0;
        endcase
    end

    mcpwc_proc #(
        .CHANNELS      (CHANNELS),
        .MAX_OVERFLOWS (MAX_OVERFLOWS)
    ) u_proc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .pin_levels (s_tdata),
        .period     (period_reg),
        .threshold  (thresh_reg),
        .stall      (stall),
        .cap_valid  (cap_valid),
        .cap        (cap)
    );

    mcpwc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap_valid (cap_valid),
        .cap       (cap),
        .stall     (stall),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_stall_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> (m_tvalid && !m_tready && cap_valid && cap.res))
        else $error("processing stalled while the output register could move");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_OUT_W-1:CHAN_FIELD_W+WIDTH_W] == '0))
        else $error("result padding bits not zero");

endmodule

/* dv/multi_channel_pulse_width_capture_top_tb.sv */
// Self-checking testbench for the eight-channel pulse width capture block.
`timescale 1ns / 100ps

module multi_channel_pulse_width_capture_top_tb;
    import mcpwc_pkg::*;

    localparam int NCH            = DEF_CHANNELS;
    localparam int MAX_OVF        = DEF_MAX_OVERFLOWS;
    localparam int SETTLE_CYCLES  = 3 * (DEF_CHANNELS + 3);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;

    typedef struct packed {
        logic [CHAN_FIELD_W-1:0] chan;
        logic [WIDTH_W-1:0]      width;
        logic                    tlast;
    } width_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIN_W-1:0]       s_tdata;    // [7:0] pin_levels
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;    // [2:0] channel, [24:3] width, rest zero
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    multi_channel_pulse_width_capture_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [COUNT_W-1:0] cfg_period;
    logic [WIDTH_W-1:0] cfg_thresh;
    logic [PIN_W-1:0]   prev_pins;
    logic [COUNT_W-1:0] tick_cnt [NCH];
    logic [5:0]         ovf_cnt [NCH];
    logic               in_pulse [NCH];
    logic [WIDTH_W-1:0] last_w [NCH];

    width_report_t    width_exp_q[$];
    logic [PIN_W-1:0] pin_q[$];

    int unsigned ticks_sent;
    int unsigned ticks_taken;
    int unsigned errors;
    int unsigned idle_cycles;
    logic        s_took;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    logic        long_hold_done;

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic capture_tick(input logic [PIN_W-1:0] pins);
        width_report_t held;
        logic          have;
        logic          fin;
        logic [WIDTH_W-1:0] w;
        logic [WIDTH_W-1:0] up;
        logic [WIDTH_W-1:0] dn;
        have = 1'b0;
        held = '0;
        for (int c = 0; c < NCH; c++) begin
            fin = 1'b0;
            w = '0;
            if (pins[c] && !prev_pins[c]) begin
                tick_cnt[c] = '0;
                ovf_cnt[c] = '0;
                in_pulse[c] = 1'b1;
            end else if (in_pulse[c]) begin
                if (!pins[c]) begin
                    w = {ovf_cnt[c], tick_cnt[c]};
                    in_pulse[c] = 1'b0;
                    fin = 1'b1;
                end else if (tick_cnt[c] >= cfg_period) begin
                    tick_cnt[c] = '0;
                    if (ovf_cnt[c] >= 6'(MAX_OVF)) begin
                        w = {6'(MAX_OVF), 16'hFFFF};
                        in_pulse[c] = 1'b0;
                        fin = 1'b1;
                    end else begin
                        ovf_cnt[c] = ovf_cnt[c] + 6'd1;
                    end
                end else begin
                    tick_cnt[c] = tick_cnt[c] + 16'd1;
                end
            end
            if (fin) begin
                up = w - last_w[c];
                dn = last_w[c] - w;
                if (up < cfg_thresh || dn > cfg_thresh) begin
                    last_w[c] = w;
                    if (have)
                        width_exp_q.push_back(held);
                    held.chan = CHAN_FIELD_W'(c);
                    held.width = w;
                    held.tlast = 1'b0;
                    have = 1'b1;
                end
            end
        end
        prev_pins = pins;
        if (have) begin
            held.tlast = 1'b1;
            width_exp_q.push_back(held);
        end
    endtask

    // monitor: predict on input, check on output, watchdog
    always @(posedge aclk) begin : monitor
        width_report_t got;
        width_report_t want;
        s_took = s_tvalid && s_tready;
        if (!aresetn) begin
            cfg_period = PERIOD_RESET;
            cfg_thresh = THRESH_RESET;
            prev_pins = '0;
            for (int c = 0; c < NCH; c++) begin
                tick_cnt[c] = '0;
                ovf_cnt[c] = '0;
                in_pulse[c] = 1'b0;
                last_w[c] = '0;
            end
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == APB_ADDR_W'(4 * int'(REG_PERIOD)))
                    cfg_period = pwdata[COUNT_W-1:0];
                else if (paddr == APB_ADDR_W'(4 * int'(REG_THRESH)))
                    cfg_thresh = pwdata[WIDTH_W-1:0];
            end
            if (s_took) begin
                capture_tick(s_tdata);
                ticks_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.chan = m_tdata[CHAN_FIELD_W-1:0];
                got.width = m_tdata[CHAN_FIELD_W +: WIDTH_W];
                got.tlast = m_tlast;
                if (width_exp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result chan %0d width %0d last %0b",
                                 $realtime, got.chan, got.width, got.tlast);
                end else begin
                    want = width_exp_q.pop_front();
                    if (got.chan !== want.chan || got.width !== want.width ||
                        got.tlast !== want.tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch exp chan %0d width %0d last %0b, got chan %0d width %0d last %0b",
                                     $realtime, want.chan, want.width, want.tlast,
                                     got.chan, got.width, got.tlast);
                    end
                end
            end
        end
        if (s_took || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sender: bursts with random gaps
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pin_q.size() > 0) begin
                s_tdata <= pin_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern, one long hold-off mid-run
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && ticks_taken >= 200) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 80);
            end else begin
                mode_left--;
            end
            case (mode)
                0, 1: m_tready <= 1'b1;
                2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (ticks_taken != ticks_sent || width_exp_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic send_pins(input logic [PIN_W-1:0] pins);
        pin_q.push_back(pins);
        ticks_sent++;
    endtask

    // mostly sticky pulse trains, some pure noise
    task automatic random_phase(input int unsigned n, input int unsigned flip_div,
                                input int unsigned noise_pct,
                                inout logic [PIN_W-1:0] pins);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                pins = PIN_W'($urandom);
            end else begin
                for (int c = 0; c < NCH; c++)
                    if ($urandom_range(0, flip_div - 1) == 0)
                        pins[c] = ~pins[c];
            end
            send_pins(pins);
        end
        wait_idle();
    endtask

    initial begin : stimulus
        logic [PIN_W-1:0] pins;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_took = 1'b0;
        ticks_sent = 0;
        ticks_taken = 0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 1;
        gap_left = 0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        long_hold_done = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed ticks at reset settings
        send_pins(8'h00);
        repeat (3) send_pins(8'hFF);
        send_pins(8'h00);
        send_pins(8'h55);
        send_pins(8'hAA);
        send_pins(8'h00);
        send_pins(8'h01);
        send_pins(8'h01);
        send_pins(8'h00);
        repeat (4) send_pins(8'h80);
        send_pins(8'h00);
        repeat (6) send_pins(8'hF0);
        wait_idle();
        pins = 8'hF0;

        // lower the period under running counters, widest threshold
        reg_write(REG_PERIOD, {16'($urandom), 16'd3});
        reg_write(REG_THRESH, {10'($urandom), 22'h3FFFFF});
        random_phase(60, 6, 10, pins);

        // period zero: overflow every tick, long pulses reach saturation
        reg_write(REG_PERIOD, 32'd0);
        reg_write(REG_THRESH, 32'd0);
        random_phase(90, 60, 0, pins);

        reg_write(REG_PERIOD, 32'd1);
        reg_write(REG_THRESH, 32'd5);
        random_phase(80, 4, 20, pins);

        reg_write(REG_PERIOD, {16'($urandom), 16'hFFFF});
        reg_write(REG_THRESH, {10'($urandom), 22'd2500});
        random_phase(60, 5, 10, pins);

        reg_write(REG_PERIOD, APB_DATA_W'($urandom_range(2, 40)));
        reg_write(REG_THRESH, APB_DATA_W'($urandom_range(0, 300)));
        random_phase(60, 8, 10, pins);

        reg_write(REG_PERIOD, 32'd2);
        reg_write(REG_THRESH, 32'h003F_FFFE);
        random_phase(50, 3, 30, pins);

        if (errors == 0 && width_exp_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
